>>> sv/qsp_pkg.sv
package qsp_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned CountW  = 3;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned DefQueueDepth = 2;

  localparam logic [KindW-1:0] KindKey     = 2'd0;
  localparam logic [KindW-1:0] KindValue   = 2'd1;
  localparam logic [KindW-1:0] KindPairEnd = 2'd2;
  localparam logic [KindW-1:0] KindEnd     = 2'd3;

  localparam logic [ByteW-1:0] ChAmp = 8'h26;
  localparam logic [ByteW-1:0] ChEq  = 8'h3D;
  localparam logic [ByteW-1:0] ChPct = 8'h25;

  localparam logic CmdChar = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  // All results caused by one accepted item, in order.
  typedef struct packed {
    logic [CountW-1:0]            count;
    logic [MaxRes-1:0][KindW-1:0] kind;
    logic [MaxRes-1:0][ByteW-1:0] data;
  } bundle_t;

  function automatic logic hex_ok(input logic [ByteW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Letters have low nibble 1..6 in both cases, so adding nine gives 10..15.
  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

>>> sv/qsp_if.sv
interface qsp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [qsp_pkg::ByteW-1:0]      char_byte;

  modport source (output valid, output cmd, output char_byte, input ready);
  modport sink   (input valid, input cmd, input char_byte, output ready);
endinterface

interface qsp_out_if;
  logic                           valid;
  logic                           ready;
  logic [qsp_pkg::KindW-1:0]      kind;
  logic [qsp_pkg::ByteW-1:0]      out_byte;
  logic                           last_of_run;

  modport source (output valid, output kind, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input last_of_run,
                  output ready);
endinterface

>>> sv/query_string_pair_tokenizer_unit.sv
// Query string tokeniser with percent decoding. Each input item is either one raw
// character (cmd 0) or the end of the string (cmd 1). The string is split at '&'
// into pairs whose key ends at the first '='; empty items and items that start
// with '=' are dropped. Key and value bytes are percent-decoded and come out one
// per result, tagged key or value, each pair closes with a pair-end result and
// the string with an end result; last_of_run marks the final result of an item.
// Rate: the input takes one item per cycle while the queue has room. An item
// gives at most four results, which the back end hands out one per cycle
// while the output is not stalled; items that give no result are not queued.
// The queue of QueueDepth result groups between the classifier and the output
// stage absorbs short bursts of multi-result items.
module query_string_pair_tokenizer_unit #(
  parameter int unsigned QueueDepth = qsp_pkg::DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qsp_in_if.sink     in_i,
  qsp_out_if.source  out_o
);

  logic             q_full;
  logic             push;
  logic             pop;
  logic             head_valid;
  qsp_pkg::bundle_t push_bundle;
  qsp_pkg::bundle_t head_bundle;

  // Front end: tracks pair phase and pending escape, and builds the full group of
  // results for each accepted item in the same cycle.
  qsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .cmd_i       (in_i.cmd),
    .char_byte_i (in_i.char_byte),
    .q_full_i    (q_full),
    .push_o      (push),
    .bundle_o    (push_bundle)
  );

  // Result groups wait here, so the input keeps flowing while the output stalls, until the queue is full.
  qsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_bundle),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_bundle)
  );

  // Back end: walks through the head group and presents one result per cycle,
  // while the output is not stalled, from a registered output stage.
  qsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_bundle),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .kind_o        (out_o.kind),
    .out_byte_o    (out_o.out_byte),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

>>> sv/qsp_front.sv
module qsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [7:0]        char_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output qsp_pkg::bundle_t  bundle_o
);

  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhKey   = 2'd1;
  localparam logic [1:0] PhValue = 2'd2;
  localparam logic [1:0] PhSkip  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [1:0] esc_q, esc_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  qsp_pkg::bundle_t b;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic [qsp_pkg::CountW-1:0] n;
    logic [1:0]                 e;
    logic                       do_dec;
    logic                       done;
    logic [1:0]                 k;
    logic [7:0]                 c;

    c       = char_byte_i;
    n       = '0;
    b       = '0;
    do_dec  = 1'b0;
    done    = 1'b0;
    phase_d = phase_q;
    held_d  = held_q;
    // The spare escape code is taken as no escape pending.
    e       = (esc_q == 2'd3) ? 2'd0 : esc_q;
    esc_d   = e;
    k       = (phase_q == PhKey) ? qsp_pkg::KindKey : qsp_pkg::KindValue;

    if (cmd_i == qsp_pkg::CmdEnd) begin
      if (phase_q == PhKey || phase_q == PhValue) begin
        if (e != 2'd0) begin
          b.kind[n[1:0]] = k; b.data[n[1:0]] = qsp_pkg::ChPct; n = n + 1'b1;
        end
        if (e == 2'd2) begin
          b.kind[n[1:0]] = k; b.data[n[1:0]] = held_q; n = n + 1'b1;
        end
        b.kind[n[1:0]] = qsp_pkg::KindPairEnd; b.data[n[1:0]] = '0; n = n + 1'b1;
      end
      b.kind[n[1:0]] = qsp_pkg::KindEnd; b.data[n[1:0]] = '0; n = n + 1'b1;
      phase_d = PhStart;
      esc_d   = 2'd0;
    end else begin
      unique case (phase_q)
        PhStart: begin
          if (c == qsp_pkg::ChEq) begin
            phase_d = PhSkip;
          end else if (c != qsp_pkg::ChAmp) begin
            phase_d = PhKey;
            e       = 2'd0;
            k       = qsp_pkg::KindKey;
            do_dec  = 1'b1;
          end
        end
        PhSkip: begin
          if (c == qsp_pkg::ChAmp) begin
            phase_d = PhStart;
          end
        end
        default: begin
          if (c == qsp_pkg::ChAmp || (c == qsp_pkg::ChEq && phase_q == PhKey)) begin
            if (e != 2'd0) begin
              b.kind[n[1:0]] = k; b.data[n[1:0]] = qsp_pkg::ChPct; n = n + 1'b1;
            end
            if (e == 2'd2) begin
              b.kind[n[1:0]] = k; b.data[n[1:0]] = held_q; n = n + 1'b1;
            end
            esc_d = 2'd0;
            if (c == qsp_pkg::ChAmp) begin
              b.kind[n[1:0]] = qsp_pkg::KindPairEnd; b.data[n[1:0]] = '0;
              n = n + 1'b1;
              phase_d = PhStart;
            end else begin
              phase_d = PhValue;
            end
          end else begin
            do_dec = 1'b1;
          end
        end
      endcase

      if (do_dec) begin
        esc_d = 2'd0;
        if (e == 2'd1) begin
          if (qsp_pkg::hex_ok(c)) begin
            held_d = c;
            esc_d  = 2'd2;
            done   = 1'b1;
          end else begin
            b.kind[n[1:0]] = k; b.data[n[1:0]] = qsp_pkg::ChPct; n = n + 1'b1;
          end
        end else if (e == 2'd2) begin
          if (qsp_pkg::hex_ok(c)) begin
            b.kind[n[1:0]] = k;
            b.data[n[1:0]] = {qsp_pkg::hex_val(held_q), qsp_pkg::hex_val(c)};
            n = n + 1'b1;
            done = 1'b1;
          end else begin
            b.kind[n[1:0]] = k; b.data[n[1:0]] = qsp_pkg::ChPct; n = n + 1'b1;
            b.kind[n[1:0]] = k; b.data[n[1:0]] = held_q; n = n + 1'b1;
          end
        end
        if (!done) begin
          if (c == qsp_pkg::ChPct) begin
            esc_d = 2'd1;
          end else begin
            b.kind[n[1:0]] = k; b.data[n[1:0]] = c; n = n + 1'b1;
          end
        end
      end
    end
    b.count = n;
  end

  assign bundle_o = b;
  assign push_o   = accept && (b.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      esc_q   <= 2'd0;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      held_q  <= held_d;
    end
  end

endmodule

>>> sv/qsp_queue.sv
module qsp_queue #(
  parameter int unsigned Depth = qsp_pkg::DefQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qsp_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output qsp_pkg::bundle_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  qsp_pkg::bundle_t  slots_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> sv/qsp_back.sv
module qsp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  qsp_pkg::bundle_t           head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [qsp_pkg::KindW-1:0]  kind_o,
  output logic [qsp_pkg::ByteW-1:0]  out_byte_o,
  output logic                       last_of_run_o
);

  logic [qsp_pkg::IdxW-1:0]  idx_q;
  logic                      valid_q;
  logic [qsp_pkg::KindW-1:0] kind_q;
  logic [qsp_pkg::ByteW-1:0] byte_q;
  logic                      last_q;
  logic                      load;
  logic                      is_last;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign is_last = ({1'b0, idx_q} == (head_i.count - 1'b1));
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind[idx_q];
      byte_q <= head_i.data[idx_q];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;

endmodule
